// ===== rtl/core/robin_hood_hash_table_top_macros.svh =====
// Assertion macros for the Robin Hood hash table RTL.
// Included by the top level; no other dependencies.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication failed");
// Next-cycle implication, checked out of reset.
`define RH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define RH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/rh_pkg.sv =====
// Shared types and constants of the Robin Hood hash table.
// No dependencies.
package rh_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int START_W  = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 10;
    localparam int SLOT_W   = 10;
    localparam int DIST_W   = 10;
    localparam int LIMIT_W  = 10;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);
    localparam logic [DIST_W-1:0]  DIST_MAX    = DIST_W'(1023);

    // FNV-1a 64: multiplier is 2^40 + 0x1B3
    localparam logic [KEY_W-1:0] HASH_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]       HASH_MULT_LO  = 9'h1B3;
    localparam int               HASH_MULT_SHL = 40;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic                clr_step;
        logic                load_in;
        logic                hash_step;
        logic                probe_init;
        logic                scan_init;
        logic                mem_rd;
        logic                advance;
        logic                place_step;
        logic                update_write;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic            clr_done;
        logic            hash_last;
        logic            hit;
        logic            occupied;
        logic            probe_last;
        logic            scan_last;
        logic            scan_oob;
        logic            full;
        logic [OP_W-1:0] op;
    } sts_t;

endpackage

// ===== rtl/core/rh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/rh_ctrl.sv =====
// Sequencer of the Robin Hood hash table: clear, hash, probe, place, scan.
// Depends on rh_pkg.
module rh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rh_pkg::sts_t  sts,
    output rh_pkg::cmd_t  cmd
);
    import rh_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DISPATCH  = 4'd2;
    localparam logic [3:0] S_HASH      = 4'd3;
    localparam logic [3:0] S_HOME      = 4'd4;
    localparam logic [3:0] S_FIND_RD   = 4'd5;
    localparam logic [3:0] S_FIND_CHK  = 4'd6;
    localparam logic [3:0] S_PLACE_RD  = 4'd7;
    localparam logic [3:0] S_PLACE_CHK = 4'd8;
    localparam logic [3:0] S_SCAN_RD   = 4'd9;
    localparam logic [3:0] S_SCAN_CHK  = 4'd10;
    localparam logic [3:0] S_RESP      = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic                mvalid_reg, mvalid_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.op inside {OP_LOOKUP, OP_INSERT}) begin
                    state_next = S_HASH;
                end else if (sts.op == OP_SCAN && !sts.scan_oob) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end else begin
                    code_next  = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) begin
                    state_next = S_HOME;
                end
            end
            S_HOME: begin
                cmd.probe_init = 1'b1;
                state_next     = S_FIND_RD;
            end
            S_FIND_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (sts.hit) begin
                    if (sts.op == OP_INSERT) begin
                        cmd.update_write = 1'b1;
                        code_next        = ST_UPDATED;
                    end else begin
                        code_next = ST_FOUND;
                    end
                    state_next = S_RESP;
                end else if (!sts.occupied || sts.probe_last) begin
                    if (sts.op == OP_LOOKUP) begin
                        code_next  = ST_NOT_FOUND;
                        state_next = S_RESP;
                    end else if (sts.full) begin
                        code_next  = ST_FULL;
                        state_next = S_RESP;
                    end else begin
                        cmd.probe_init = 1'b1;
                        state_next     = S_PLACE_RD;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_FIND_RD;
                end
            end
            S_PLACE_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_PLACE_CHK;
            end
            S_PLACE_CHK: begin
                cmd.place_step = 1'b1;
                if (!sts.occupied) begin
                    code_next  = ST_INSERTED;
                    state_next = S_RESP;
                end else begin
                    state_next = S_PLACE_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (sts.occupied) begin
                    code_next  = ST_FOUND;
                    state_next = S_RESP;
                end else if (sts.scan_last) begin
                    code_next  = ST_NOT_FOUND;
                    state_next = S_RESP;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!mvalid_reg || m_ready) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = code_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.res_load) begin
            mvalid_next = 1'b1;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            code_reg   <= ST_NOT_FOUND;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;
endmodule

// ===== rtl/core/rh_dp.sv =====
// Datapath of the Robin Hood hash table: FNV-1a hash unit, probe
// registers, carried entry, slot RAM and result register. Depends on rh_pkg, rh_ram.
module rh_dp #(
    parameter int CAPACITY    = rh_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = rh_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rh_pkg::cmd_t                 cmd,
    output rh_pkg::sts_t                 sts,
    input  logic                         cfg_we,
    input  logic [rh_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  logic [rh_pkg::OP_W-1:0]      s_opcode,
    input  logic [rh_pkg::KEY_W-1:0]     s_key,
    input  logic [rh_pkg::LEN_W-1:0]     s_key_bytes,
    input  logic [VALUE_WIDTH-1:0]       s_value,
    input  logic [rh_pkg::START_W-1:0]   s_start_slot,
    output logic [rh_pkg::STATUS_W-1:0]  m_status,
    output logic [VALUE_WIDTH-1:0]       m_value_out,
    output logic [rh_pkg::KEY_W-1:0]     m_key_out,
    output logic [rh_pkg::LEN_W-1:0]     m_key_bytes_out,
    output logic [rh_pkg::SLOT_W-1:0]    m_slot_out,
    output logic [rh_pkg::COUNT_W-1:0]   m_count_out
);
    import rh_pkg::*;

    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int DIST_LO   = 0;
    localparam int VAL_LO    = DIST_LO + DIST_W;
    localparam int LEN_LO    = VAL_LO + VALUE_WIDTH;
    localparam int KEY_LO    = LEN_LO + LEN_W;
    localparam int VALID_BIT = KEY_LO + KEY_W;
    localparam int ENTRY_W   = VALID_BIT + 1;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        if (raw == '0) begin
            n = LEN_W'(1);
        end else if (raw > LEN_W'(8)) begin
            n = LEN_W'(8);
        end else begin
            n = raw;
        end
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k,
                                                  input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] t;
        t = k;
        for (int b = 0; b < 8; b++) begin
            if (LEN_W'(b) >= n) begin
                t[b*8 +: 8] = 8'h00;
            end
        end
        return t;
    endfunction

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
        return (d == DIST_MAX) ? d : d + DIST_W'(1);
    endfunction

    // operation registers
    logic [OP_W-1:0]        op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [START_W-1:0]     start_reg;
    logic [KEY_W-1:0]       hash_reg, hash_next;
    logic [2:0]             byte_reg;
    logic [IDX_W-1:0]       idx_reg, probe_reg, rest_reg, clr_reg;
    logic                   swapped_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [COUNT_W-1:0]     count_reg;

    // entry being carried along the probe
    logic [KEY_W-1:0]       ckey_reg;
    logic [LEN_W-1:0]       clen_reg;
    logic [VALUE_WIDTH-1:0] cval_reg;
    logic [DIST_W-1:0]      cdist_reg;

    // slot RAM
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata, q;
    logic                   q_valid;
    logic [KEY_W-1:0]       q_key;
    logic [LEN_W-1:0]       q_len;
    logic [VALUE_WIDTH-1:0] q_val;
    logic [DIST_W-1:0]      q_dist;
    logic                   displace;

    logic [KEY_W-1:0]       hx;
    logic [7:0]             hbyte;

    assign q_valid = q[VALID_BIT];
    assign q_key   = q[KEY_LO +: KEY_W];
    assign q_len   = q[LEN_LO +: LEN_W];
    assign q_val   = q[VAL_LO +: VALUE_WIDTH];
    assign q_dist  = q[DIST_LO +: DIST_W];
    assign displace = q_dist < cdist_reg;

    // FNV-1a step: xor byte, multiply by 2^40 + 0x1B3
    assign hbyte     = key_reg[{byte_reg, 3'b000} +: 8];
    assign hx        = hash_reg ^ KEY_W'(hbyte);
    assign hash_next = (hx << HASH_MULT_SHL) + KEY_W'(hx * KEY_W'(HASH_MULT_LO));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
        end else if (cmd.place_step && (!q_valid || displace)) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, ckey_reg, clen_reg, cval_reg, cdist_reg};
        end else if (cmd.update_write) begin
            ram_we    = 1'b1;
            ram_wdata = q;
            ram_wdata[VAL_LO +: VALUE_WIDTH] = val_reg;
        end
    end

    rh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.mem_rd),
        .raddr (idx_reg),
        .rdata (q)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            limit_reg <= LIMIT_RESET;
            count_reg <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.res_load && cmd.res_status == ST_INSERTED) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= s_opcode;
            len_reg   <= clamp_len(s_key_bytes);
            key_reg   <= trim_key(s_key, clamp_len(s_key_bytes));
            val_reg   <= s_value;
            start_reg <= s_start_slot;
            hash_reg  <= HASH_BASIS;
            byte_reg  <= '0;
        end
        if (cmd.hash_step) begin
            hash_reg <= hash_next;
            byte_reg <= byte_reg + 3'd1;
        end
        if (cmd.probe_init) begin
            idx_reg     <= hash_reg[IDX_W-1:0];
            probe_reg   <= '0;
            ckey_reg    <= key_reg;
            clen_reg    <= len_reg;
            cval_reg    <= val_reg;
            cdist_reg   <= '0;
            swapped_reg <= 1'b0;
        end
        if (cmd.scan_init) begin
            idx_reg <= IDX_W'(start_reg);
        end
        if (cmd.advance) begin
            idx_reg   <= idx_reg + IDX_W'(1);
            probe_reg <= probe_reg + IDX_W'(1);
        end
        if (cmd.place_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (!q_valid || displace) begin
                if (!swapped_reg) begin
                    rest_reg <= idx_reg;
                end
            end
            if (q_valid && displace) begin
                // swap: carry the richer resident onward
                swapped_reg <= 1'b1;
                ckey_reg    <= q_key;
                clen_reg    <= q_len;
                cval_reg    <= q_val;
                cdist_reg   <= sat_inc(q_dist);
            end else begin
                cdist_reg <= sat_inc(cdist_reg);
            end
        end
        if (cmd.res_load) begin
            m_status        <= cmd.res_status;
            m_value_out     <= '0;
            m_key_out       <= '0;
            m_key_bytes_out <= '0;
            m_slot_out      <= '0;
            m_count_out     <= count_reg;
            case (cmd.res_status)
                ST_FOUND: begin
                    m_value_out <= q_val;
                    m_slot_out  <= SLOT_W'(idx_reg);
                    if (op_reg == OP_SCAN) begin
                        m_key_out       <= q_key;
                        m_key_bytes_out <= q_len;
                    end
                end
                ST_UPDATED: begin
                    m_slot_out <= SLOT_W'(idx_reg);
                end
                ST_INSERTED: begin
                    m_slot_out  <= SLOT_W'(rest_reg);
                    m_count_out <= count_reg + COUNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sts.clr_done   = clr_reg == {IDX_W{1'b1}};
        sts.hash_last  = LEN_W'(byte_reg) + LEN_W'(1) == len_reg;
        sts.hit        = q_valid && q_len == len_reg && q_key == key_reg;
        sts.occupied   = q_valid;
        sts.probe_last = probe_reg == {IDX_W{1'b1}};
        sts.scan_last  = idx_reg == {IDX_W{1'b1}};
        sts.scan_oob   = 32'(start_reg) >= 32'(CAPACITY);
        sts.full       = count_reg >= limit_reg || 32'(count_reg) >= 32'(CAPACITY);
        sts.op         = op_reg;
    end
endmodule

// ===== rtl/core/robin_hood_hash_table_top.sv =====
// Top level of the Robin Hood hash table: sequencer plus datapath.
// Depends on rh_pkg, rh_ctrl, rh_dp and the assertion macro header.
//
//   channel  direction  handshake           payload
//   s_*      in         s_valid / s_ready   opcode, key, key_bytes, value, start_slot
//   m_*      out        m_valid / m_ready   status, value_out, key_out, key_bytes_out,
//                                           slot_out, count_out
//   cfg_*    in         cfg_we (no wait)    entry_limit
//
// One word is worked at a time. A lookup or insert hashes its key_bytes
// bytes (one FNV-1a multiply each), then probes slots in the slot RAM
// (read, then check); an insert of a new key probes its run twice. A scan
// reads and checks slots from start_slot onward. After reset a clearing
// pass writes every slot once with s_ready low; cfg writes are taken
// meanwhile. A finished word waits in the output register; s_ready
// returns as soon as it is loaded, so a stalled m_ready blocks only the
// next response.
`include "robin_hood_hash_table_top_macros.svh"
module robin_hood_hash_table_top #(
    parameter int CAPACITY    = rh_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = rh_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [rh_pkg::LIMIT_W-1:0]   cfg_wdata,
    // request words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rh_pkg::OP_W-1:0]      s_opcode,
    input  logic [rh_pkg::KEY_W-1:0]     s_key,
    input  logic [rh_pkg::LEN_W-1:0]     s_key_bytes,
    input  logic [VALUE_WIDTH-1:0]       s_value,
    input  logic [rh_pkg::START_W-1:0]   s_start_slot,
    // response words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rh_pkg::STATUS_W-1:0]  m_status,
    output logic [VALUE_WIDTH-1:0]       m_value_out,
    output logic [rh_pkg::KEY_W-1:0]     m_key_out,
    output logic [rh_pkg::LEN_W-1:0]     m_key_bytes_out,
    output logic [rh_pkg::SLOT_W-1:0]    m_slot_out,
    output logic [rh_pkg::COUNT_W-1:0]   m_count_out
);
    import rh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: owns the handshakes and walks the probe loops.
    rh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: hash unit, slot RAM, carried entry, result register.
    rh_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_opcode        (s_opcode),
        .s_key           (s_key),
        .s_key_bytes     (s_key_bytes),
        .s_value         (s_value),
        .s_start_slot    (s_start_slot),
        .m_status        (m_status),
        .m_value_out     (m_value_out),
        .m_key_out       (m_key_out),
        .m_key_bytes_out (m_key_bytes_out),
        .m_slot_out      (m_slot_out),
        .m_count_out     (m_count_out)
    );

    // Never overwrite a response that is still waiting.
    `RH_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.res_load, !m_valid || m_ready)
    // An insert never lands once the table is at its limit.
    `RH_ASSERT_IMPL(a_insert_room, aclk, aresetn, cmd.res_load && cmd.res_status == ST_INSERTED, !sts.full)
    // No word is taken during the clearing pass.
    `RH_ASSERT_IMPL(a_clear_blocks, aclk, aresetn, cmd.clr_step, !s_ready)
    // One word in flight: ready drops right after an accept.
    `RH_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule
